/* hdl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing else.
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int KEY_W         = 16;
    localparam int TAG_W         = 16;
    localparam int COUNT_W       = 5;

    typedef enum logic [1:0] {
        ACT_INSERT     = 2'd0,
        ACT_REMOVE_MIN = 2'd1,
        ACT_REMOVE_MAX = 2'd2,
        ACT_CLEAR      = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        action_t                   action;
        logic signed [KEY_W-1:0]   priority_req;
        logic        [TAG_W-1:0]   payload;
    } req_word_t;

    typedef struct packed {
        status_t                   status;
        logic signed [KEY_W-1:0]   out_priority;
        logic        [TAG_W-1:0]   out_payload;
        logic        [COUNT_W-1:0] entry_count;
    } rsp_word_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic        [TAG_W-1:0] tag;
    } entry_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic   insert_en;
        logic   remove_en;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

/* hdl/spq_cell.sv */
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       in_use,
    input  logic       left_le,
    input  entry_t     left_entry,
    input  entry_t     right_entry,
    output logic       le,
    output entry_t     entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // Occupied slots holding a key no greater than the new one stay ahead of it.
    assign le    = in_use && (entry_reg.key <= ctrl.new_entry.key);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert_en)
        begin
            if (le)
                entry_next = entry_reg;
            else if (left_le)
                entry_next = ctrl.new_entry;
            else
                entry_next = left_entry;
        end
        else if (ctrl.remove_en)
        begin
            // advance toward the head
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* hdl/sorted_priority_queue.sv */
// Sorted priority queue: a row of DEPTH shifting cells kept in ascending key order.
// The response word is registered: it appears in the cycle after the request word is accepted.
// Throughput: one request word per cycle while the response side is not stalled.
// All cells compare against the new key in parallel.
// Reset clears the entry count and the response valid; cell contents stay undefined.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_word_t        rsp_reg;
    rsp_word_t        rsp_next;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic [IDX_W-1:0] tail_idx;
    logic [OCC_W-1:0] occ_m1;
    logic [OCC_W+COUNT_W-1:0] count_ext;
    cell_ctrl_t       ctrl;

    entry_t           entries [DEPTH];
    logic             le_vec  [DEPTH];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign is_full  = (occ_reg == OCC_W'(DEPTH));
    assign is_empty = (occ_reg == '0);
    assign occ_m1   = occ_reg - OCC_W'(1);
    assign tail_idx = occ_m1[IDX_W-1:0];

    assign ctrl.insert_en = accept && (req.action == ACT_INSERT) && !is_full;
    assign ctrl.remove_en = accept && (req.action == ACT_REMOVE_MIN) && !is_empty;
    assign ctrl.new_entry.key = req.priority_req;
    assign ctrl.new_entry.tag = req.payload;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic   in_use;
        logic   left_le;
        entry_t left_entry;
        entry_t right_entry;

        assign in_use = (OCC_W'(i) < occ_reg);

        if (i == 0)
        begin : g_head
            assign left_le    = 1'b1;
            assign left_entry = ctrl.new_entry;
        end
        else
        begin : g_body
            assign left_le    = le_vec[i-1];
            assign left_entry = entries[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_entry = entries[i];
        end
        else
        begin : g_mid
            assign right_entry = entries[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .in_use      (in_use),
            .left_le     (left_le),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .le          (le_vec[i]),
            .entry       (entries[i])
        );
    end

    always_comb
    begin
        occ_next       = occ_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        count_ext      = '0;
        if (accept)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.status       = ST_OK;
            rsp_next.out_priority = '0;
            rsp_next.out_payload  = '0;
            case (req.action)
                ACT_INSERT:
                begin
                    if (is_full)
                        rsp_next.status = ST_FULL;
                    else
                        occ_next = occ_reg + OCC_W'(1);
                end
                ACT_REMOVE_MIN:
                begin
                    if (is_empty)
                        rsp_next.status = ST_EMPTY;
                    else
                    begin
                        occ_next              = occ_m1;
                        rsp_next.out_priority = entries[0].key;
                        rsp_next.out_payload  = entries[0].tag;
                    end
                end
                ACT_REMOVE_MAX:
                begin
                    if (is_empty)
                        rsp_next.status = ST_EMPTY;
                    else
                    begin
                        occ_next              = occ_m1;
                        rsp_next.out_priority = entries[tail_idx].key;
                        rsp_next.out_payload  = entries[tail_idx].tag;
                    end
                end
                ACT_CLEAR:
                begin
                    occ_next = '0;
                end
                default:
                begin
                    occ_next = occ_reg;
                end
            endcase
            // mask the count to the field width
            count_ext            = {{COUNT_W{1'b0}}, occ_next};
            rsp_next.entry_count = count_ext[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule
